[design/kdt_pkg.sv]
`default_nettype none
package kdt_pkg;

    localparam int ADDR_W  = 48;
    localparam int WORD_W  = 16;
    localparam int OP_W    = 3;
    localparam int SEL_W   = 2;
    localparam int OUTC_W  = 3;
    localparam int IDX_W   = 4;

    localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
    localparam logic [OP_W-1:0] OP_REM_ADDR = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_CID  = 3'd2;
    localparam logic [OP_W-1:0] OP_UPD_CID  = 3'd3;
    localparam logic [OP_W-1:0] OP_UPD_ADDR = 3'd4;

    localparam logic [SEL_W-1:0] FS_CID    = 2'd0;
    localparam logic [SEL_W-1:0] FS_STATUS = 2'd1;
    localparam logic [SEL_W-1:0] FS_MTU    = 2'd2;

    localparam logic [OUTC_W-1:0] OC_ADDED   = 3'd0;
    localparam logic [OUTC_W-1:0] OC_DUP     = 3'd1;
    localparam logic [OUTC_W-1:0] OC_FULL    = 3'd2;
    localparam logic [OUTC_W-1:0] OC_REMOVED = 3'd3;
    localparam logic [OUTC_W-1:0] OC_NOMATCH = 3'd4;
    localparam logic [OUTC_W-1:0] OC_UPDATED = 3'd5;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] conn_id;
        logic [WORD_W-1:0] status;
        logic [WORD_W-1:0] mtu;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

[design/kdt_ram.sv]
`default_nettype none
module kdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[design/kdt_match.sv]
`default_nettype none
module kdt_match
    import kdt_pkg::*;
(
    input  wire t_entry            i_entry,
    input  wire logic              i_by_addr,
    input  wire logic [ADDR_W-1:0] i_key_addr,
    input  wire logic [WORD_W-1:0] i_key_cid,
    output logic                   o_match
);

    always_comb begin
        if (i_by_addr) begin
            o_match = (i_entry.address == i_key_addr);
        end else begin
            o_match = (i_entry.conn_id == i_key_cid);
        end
    end

endmodule
`default_nettype wire

[design/keyed_device_table.sv]
// Keyed peer table: up to TABLE_ENTRIES link peers kept packed in slots
// 0..count-1, each holding address, connection id, status and MTU.
// Input channel: i_in_valid / o_in_stall carry one operation beat
// (register, remove by address or id, update by id or address).
// Output channel: o_out_valid / i_out_stall carry one result beat per
// operation: outcome, slot, entry count and the affected entry.
// Operation: one shared key comparator walks the table through a single
// RAM read port, reading then comparing each entry scanned. A search stops
// at the first match, but a remove scans every entry and keeps the last.
// A decide step follows; a remove then moves each later entry down a slot
// by a read and a write, and the result is handed over from a done state.
// One operation runs at a time; o_in_stall is high while it runs.
// The result sits in an output register, so the next operation is taken
// while a result still waits. If i_out_stall holds the result register,
// a finished operation waits in its last state until the register frees.
// Reset (i_rst_n low, synchronous) empties the table and drops any
// pending result; table storage itself is not cleared.
`default_nettype none
module keyed_device_table
    import kdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [ADDR_W-1:0] i_peer_address,
    input  wire logic [WORD_W-1:0] i_connection_id,
    input  wire logic [WORD_W-1:0] i_new_status,
    input  wire logic [WORD_W-1:0] i_new_mtu,
    input  wire logic [SEL_W-1:0]  i_field_select,
    input  wire logic [WORD_W-1:0] i_update_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [OUTC_W-1:0]      o_outcome,
    output logic [IDX_W-1:0]       o_slot_index,
    output logic [IDX_W-1:0]       o_entry_count,
    output logic [ADDR_W-1:0]      o_hit_address,
    output logic [WORD_W-1:0]      o_hit_connection_id,
    output logic [WORD_W-1:0]      o_hit_status,
    output logic [WORD_W-1:0]      o_hit_mtu
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_READ     = 7'b0000010,
        S_CMP      = 7'b0000100,
        S_DECIDE   = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_count, n_count;
    logic              r_found, n_found;
    logic [AW-1:0]     r_slot, n_slot;
    t_entry            r_hit, n_hit;
    logic [OUTC_W-1:0] r_outcome, n_outcome;

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_key_addr;
    logic [WORD_W-1:0] r_key_cid;
    logic [WORD_W-1:0] r_new_status;
    logic [WORD_W-1:0] r_new_mtu;
    logic [SEL_W-1:0]  r_sel;
    logic [WORD_W-1:0] r_val;

    logic              r_out_valid;
    logic [OUTC_W-1:0] r_out_outcome;
    logic [IDX_W-1:0]  r_out_slot;
    logic [IDX_W-1:0]  r_out_count;
    t_entry            r_out_hit;

    logic              accept;
    logic              by_addr;
    logic              find_last;
    logic              match;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    t_entry            mem_rdata;
    t_entry            new_entry;
    t_entry            upd_entry;
    logic              out_load;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign by_addr    = r_op inside {OP_REGISTER, OP_REM_ADDR, OP_UPD_ADDR};
    assign find_last  = r_op inside {OP_REM_ADDR, OP_REM_CID};
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign new_entry = '{address: r_key_addr, conn_id: r_key_cid,
                         status: r_new_status, mtu: r_new_mtu};

    always_comb begin
        upd_entry = r_hit;
        case (r_sel)
            FS_CID:    upd_entry.conn_id = r_val;
            FS_STATUS: upd_entry.status  = r_val;
            FS_MTU:    upd_entry.mtu     = r_val;
            default:   upd_entry = r_hit;
        endcase
    end

    kdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    kdt_match u_match (
        .i_entry    (mem_rdata),
        .i_by_addr  (by_addr),
        .i_key_addr (r_key_addr),
        .i_key_cid  (r_key_cid),
        .o_match    (match)
    );

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_count   = r_count;
        n_found   = r_found;
        n_slot    = r_slot;
        n_hit     = r_hit;
        n_outcome = r_outcome;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    if (i_op > OP_UPD_ADDR || r_count == '0) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (match) begin
                    n_found = 1'b1;
                    n_slot  = r_idx;
                    n_hit   = mem_rdata;
                end
                if ((match && !find_last) || (CW'(r_idx) + CW'(1) == r_count)) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_READ;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                case (r_op)
                    OP_REGISTER: begin
                        if (r_found) begin
                            n_outcome = OC_DUP;
                        end else if (r_count == CW'(TABLE_ENTRIES)) begin
                            n_outcome = OC_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            mem_wdata = new_entry;
                            n_hit     = new_entry;
                            n_slot    = r_count[AW-1:0];
                            n_found   = 1'b1;
                            n_count   = r_count + CW'(1);
                            n_outcome = OC_ADDED;
                        end
                    end
                    OP_REM_ADDR, OP_REM_CID: begin
                        if (r_found) begin
                            n_outcome = OC_REMOVED;
                            if (CW'(r_slot) + CW'(1) < r_count) begin
                                n_idx   = r_slot;
                                n_state = S_SHIFT_RD;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end else begin
                            n_outcome = OC_NOMATCH;
                        end
                    end
                    OP_UPD_CID, OP_UPD_ADDR: begin
                        if (r_found) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_slot;
                            mem_wdata = upd_entry;
                            n_hit     = upd_entry;
                            n_outcome = OC_UPDATED;
                        end else begin
                            n_outcome = OC_NOMATCH;
                        end
                    end
                    default: begin
                        n_found   = 1'b0;
                        n_outcome = OC_NOMATCH;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx + AW'(1);
                n_state   = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_idx     = r_idx + AW'(1);
                if (CW'(r_idx) + CW'(2) < r_count) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_found   <= n_found;
        r_slot    <= n_slot;
        r_hit     <= n_hit;
        r_outcome <= n_outcome;
        if (accept) begin
            r_op         <= i_op;
            r_key_addr   <= i_peer_address;
            r_key_cid    <= i_connection_id;
            r_new_status <= i_new_status;
            r_new_mtu    <= i_new_mtu;
            r_sel        <= i_field_select;
            r_val        <= i_update_value;
        end
        if (out_load) begin
            r_out_outcome <= r_outcome;
            r_out_count   <= IDX_W'(r_count);
            r_out_slot    <= r_found ? IDX_W'(r_slot) : '0;
            r_out_hit     <= r_found ? r_hit : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_outcome           = r_out_outcome;
    assign o_slot_index        = r_out_slot;
    assign o_entry_count       = r_out_count;
    assign o_hit_address       = r_out_hit.address;
    assign o_hit_connection_id = r_out_hit.conn_id;
    assign o_hit_status        = r_out_hit.status;
    assign o_hit_mtu           = r_out_hit.mtu;

endmodule
`default_nettype wire
